// ===== src/gbm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbm_pkg
// Shared sizes, register indexes and helpers for the grid bitmap.
// ----------------------------------------------------------------------------
package gbm_pkg;

	localparam int MAX_WIDTH   = 256;
	localparam int MAX_HEIGHT  = 256;
	localparam int WORD_BITS   = 64;
	localparam int CELLS       = MAX_WIDTH * MAX_HEIGHT;
	localparam int STORE_WORDS = (CELLS + WORD_BITS - 1) / WORD_BITS;
	localparam int ADDR_W      = $clog2(STORE_WORDS);
	localparam int OFS_W       = $clog2(WORD_BITS);
	localparam int BIX_W       = ADDR_W + OFS_W;
	localparam int CNT_W       = 17;
	localparam int DIM_W       = 9;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int ROW_W       = $clog2(MAX_HEIGHT);

	typedef enum logic [1:0] {
		CMD_SET   = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_TEST  = 2'd2,
		CMD_COUNT = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_ORIGIN_X   = 2'd0,
		REG_ORIGIN_Z   = 2'd1,
		REG_MAP_WIDTH  = 2'd2,
		REG_MAP_HEIGHT = 2'd3
	} reg_idx_t;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > maxv) begin
			r = maxv;
		end
		return r;
	endfunction

	function automatic logic [OFS_W:0] popcount(input logic [WORD_BITS-1:0] v);
		logic [OFS_W:0] n;
		n = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			n = n + (OFS_W+1)'(v[i]);
		end
		return n;
	endfunction

endpackage
`default_nettype wire

// ===== src/gbm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbm_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module gbm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end
			rdata <= mem_q[addr];
		end
	end

endmodule
`default_nettype wire

// ===== src/bounded_grid_bitmap_with_counts.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_grid_bitmap_with_counts
// Occupancy bitmap over a configured window with a running set count and
// rectangle counts.
//
// Requests enter on in_valid/in_stall, one at a time; each gives one result
// on out_valid/out_stall, held in an output register until taken.
// Set, clear and test pass through locate, address multiply and word read,
// read-modify-write and result load. The next request is taken in the
// cycle after the result loads. A rectangle count passes difference, clamp
// and init steps, then walks every bitmap word touched by each row of the
// window part (one word read per cycle from the single RAM port) and
// drains; an outside rectangle skips walk and drain, an empty one init too.
// After reset the bitmap RAM is cleared word by word, all 1024 words, while
// in_stall is high. Configuration writes are taken at any time and apply to
// later requests and to one in progress.
// While the receiver stalls, the finished result is held and the block
// waits with its next result computed but not yet loaded.
// ----------------------------------------------------------------------------
module bounded_grid_bitmap_with_counts
	import gbm_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [1:0]           cfg_index,
	input  wire logic [31:0]          cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           cmd,
	input  wire logic signed [31:0]   x,
	input  wire logic signed [31:0]   z,
	input  wire logic signed [31:0]   x_end,
	input  wire logic signed [31:0]   z_end,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      was_set,
	output logic [CNT_W-1:0]          set_total,
	output logic [CNT_W-1:0]          range_set,
	output logic [63:0]               range_cells
);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_P_LOC, ST_P_RD, ST_P_WR,
		ST_R_DIFF, ST_R_CLAMP, ST_R_INIT, ST_R_WALK, ST_R_DRAIN, ST_FIN
	} state_t;

	state_t state_q;

	logic signed [31:0] origin_x_q, origin_z_q;
	logic [DIM_W-1:0]   map_width_q, map_height_q;
	logic [DIM_W-1:0]   w_eff, h_eff;

	logic [1:0]         cmd_q;
	logic signed [31:0] x_q, z_q, xe_q, ze_q;

	logic [ADDR_W-1:0]  clr_q;
	logic [COL_W-1:0]   lx_q;
	logic [ROW_W-1:0]   lz_q;
	logic               inwin_q;
	logic [BIX_W-1:0]   bix_q;

	logic signed [32:0] dx0_q, dx1_q, dz0_q, dz1_q;
	logic [32:0]        dx_q, dz_q;
	logic               empty_q;
	logic [63:0]        prod_q;
	logic               walk_q;
	logic [COL_W-1:0]   cx0_q, cx1_q;
	logic [ROW_W-1:0]   cz0_q, cz1_q, row_q;
	logic [BIX_W-1:0]   base_q, cur_q;

	logic               pend_s1;
	logic [OFS_W-1:0]   lo_s1, hi_s1;
	logic [CNT_W-1:0]   acc_q;
	logic [CNT_W-1:0]   count_q;
	logic               was_q;

	logic               out_free;

	logic                 ram_en, ram_we;
	logic [ADDR_W-1:0]    ram_addr;
	logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

	logic signed [32:0] lx_c, lz_c;
	logic signed [32:0] cx0_c, cx1_c, cz0_c, cz1_c;
	logic [BIX_W-1:0]   row_end;
	logic [WORD_BITS-1:0] walk_mask;
	logic               bit_old;
	logic [WORD_BITS-1:0] bit_m;
	logic [CNT_W:0]     pidx;
	logic [CNT_W:0]     ibase;

	assign w_eff = eff_dim(map_width_q, DIM_W'(MAX_WIDTH));
	assign h_eff = eff_dim(map_height_q, DIM_W'(MAX_HEIGHT));

	assign lx_c = {x_q[31], x_q} - {origin_x_q[31], origin_x_q};
	assign lz_c = {z_q[31], z_q} - {origin_z_q[31], origin_z_q};

	assign cx0_c = dx0_q[32] ? '0 : dx0_q;
	assign cz0_c = dz0_q[32] ? '0 : dz0_q;
	assign cx1_c = (dx1_q > $signed({24'b0, w_eff}) - 33'sd1)
		? $signed({24'b0, w_eff}) - 33'sd1 : dx1_q;
	assign cz1_c = (dz1_q > $signed({24'b0, h_eff}) - 33'sd1)
		? $signed({24'b0, h_eff}) - 33'sd1 : dz1_q;

	assign pidx  = (CNT_W+1)'(lz_q) * (CNT_W+1)'(w_eff) + (CNT_W+1)'(lx_q);
	assign ibase = (CNT_W+1)'(cz0_q) * (CNT_W+1)'(w_eff);

	assign row_end   = base_q + BIX_W'(cx1_q);
	assign bit_m     = WORD_BITS'(1) << bix_q[OFS_W-1:0];
	assign bit_old   = inwin_q & ram_rdata[bix_q[OFS_W-1:0]];
	assign walk_mask = ({WORD_BITS{1'b1}} << lo_s1)
		& ({WORD_BITS{1'b1}} >> (OFS_W'(WORD_BITS - 1) - hi_s1));

	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = cur_q[BIX_W-1:OFS_W];
		ram_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				ram_en   = 1'b1;
				ram_we   = 1'b1;
				ram_addr = clr_q;
			end
			ST_P_RD: begin
				ram_en   = 1'b1;
				ram_addr = pidx[BIX_W-1:OFS_W];
			end
			ST_P_WR: begin
				ram_en   = 1'b1;
				ram_addr = bix_q[BIX_W-1:OFS_W];
				ram_we   = inwin_q && ((cmd_q == CMD_SET && !bit_old)
					|| (cmd_q == CMD_CLEAR && bit_old));
				ram_wdata = (cmd_q == CMD_SET) ? (ram_rdata | bit_m)
					: (ram_rdata & ~bit_m);
			end
			ST_R_WALK: begin
				ram_en = 1'b1;
			end
			default: begin
				ram_en = 1'b0;
			end
		endcase
	end

	gbm_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(STORE_WORDS)
	) u_ram (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			origin_x_q   <= '0;
			origin_z_q   <= '0;
			map_width_q  <= DIM_W'(256);
			map_height_q <= DIM_W'(256);
			clr_q        <= '0;
			count_q      <= '0;
			pend_s1      <= 1'b0;
			out_valid    <= 1'b0;
			was_set      <= 1'b0;
			set_total    <= '0;
			range_set    <= '0;
			range_cells  <= '0;
			cmd_q <= '0; x_q <= '0; z_q <= '0; xe_q <= '0; ze_q <= '0;
			lx_q <= '0; lz_q <= '0; inwin_q <= 1'b0; bix_q <= '0;
			dx0_q <= '0; dx1_q <= '0; dz0_q <= '0; dz1_q <= '0;
			dx_q <= '0; dz_q <= '0; empty_q <= 1'b0; prod_q <= '0;
			walk_q <= 1'b0; cx0_q <= '0; cx1_q <= '0; cz0_q <= '0;
			cz1_q <= '0; row_q <= '0; base_q <= '0; cur_q <= '0;
			lo_s1 <= '0; hi_s1 <= '0; acc_q <= '0; was_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_ORIGIN_X:   origin_x_q   <= cfg_data;
					REG_ORIGIN_Z:   origin_z_q   <= cfg_data;
					REG_MAP_WIDTH:  map_width_q  <= cfg_data[DIM_W-1:0];
					REG_MAP_HEIGHT: map_height_q <= cfg_data[DIM_W-1:0];
					default: ;
				endcase
			end

			if (state_q == ST_FIN && out_free) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end

			pend_s1 <= 1'b0;
			if (pend_s1) begin
				acc_q <= acc_q + CNT_W'(popcount(ram_rdata & walk_mask));
			end

			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(STORE_WORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q <= cmd;
						x_q   <= x;
						z_q   <= z;
						xe_q  <= x_end;
						ze_q  <= z_end;
						state_q <= (cmd_t'(cmd) == CMD_COUNT) ? ST_R_DIFF : ST_P_LOC;
					end
				end
				ST_P_LOC: begin
					inwin_q <= !lx_c[32] && !lz_c[32]
						&& (lx_c < $signed({24'b0, w_eff}))
						&& (lz_c < $signed({24'b0, h_eff}));
					lx_q <= lx_c[COL_W-1:0];
					lz_q <= lz_c[ROW_W-1:0];
					state_q <= ST_P_RD;
				end
				ST_P_RD: begin
					bix_q   <= pidx[BIX_W-1:0];
					state_q <= ST_P_WR;
				end
				ST_P_WR: begin
					was_q <= bit_old;
					if (inwin_q && cmd_q == CMD_SET && !bit_old) begin
						count_q <= count_q + 1'b1;
					end else if (inwin_q && cmd_q == CMD_CLEAR && bit_old) begin
						count_q <= count_q - 1'b1;
					end
					acc_q   <= '0;
					prod_q  <= '0;
					empty_q <= 1'b1;
					state_q <= ST_FIN;
				end
				ST_R_DIFF: begin
					was_q   <= 1'b0;
					empty_q <= (xe_q < x_q) || (ze_q < z_q);
					dx_q  <= 33'({xe_q[31], xe_q} - {x_q[31], x_q} + 33'sd1);
					dz_q  <= 33'({ze_q[31], ze_q} - {z_q[31], z_q} + 33'sd1);
					dx0_q <= lx_c;
					dz0_q <= lz_c;
					dx1_q <= {xe_q[31], xe_q} - {origin_x_q[31], origin_x_q};
					dz1_q <= {ze_q[31], ze_q} - {origin_z_q[31], origin_z_q};
					state_q <= ST_R_CLAMP;
				end
				ST_R_CLAMP: begin
					if (dx_q[32] && dz_q[32]) begin
						prod_q <= '1;
					end else if (dx_q[32]) begin
						prod_q <= {dz_q[31:0], 32'b0};
					end else if (dz_q[32]) begin
						prod_q <= {dx_q[31:0], 32'b0};
					end else begin
						prod_q <= dx_q[31:0] * dz_q[31:0];
					end
					walk_q <= !empty_q && (cx0_c <= cx1_c) && (cz0_c <= cz1_c);
					cx0_q  <= cx0_c[COL_W-1:0];
					cx1_q  <= cx1_c[COL_W-1:0];
					cz0_q  <= cz0_c[ROW_W-1:0];
					cz1_q  <= cz1_c[ROW_W-1:0];
					acc_q  <= '0;
					state_q <= empty_q ? ST_FIN : ST_R_INIT;
				end
				ST_R_INIT: begin
					row_q   <= cz0_q;
					base_q  <= ibase[BIX_W-1:0];
					cur_q   <= ibase[BIX_W-1:0] + BIX_W'(cx0_q);
					state_q <= walk_q ? ST_R_WALK : ST_FIN;
				end
				ST_R_WALK: begin
					pend_s1 <= 1'b1;
					lo_s1   <= cur_q[OFS_W-1:0];
					if (row_end[BIX_W-1:OFS_W] == cur_q[BIX_W-1:OFS_W]) begin
						hi_s1 <= row_end[OFS_W-1:0];
						if (row_q == cz1_q) begin
							state_q <= ST_R_DRAIN;
						end else begin
							row_q  <= row_q + 1'b1;
							base_q <= base_q + BIX_W'(w_eff);
							cur_q  <= base_q + BIX_W'(w_eff) + BIX_W'(cx0_q);
						end
					end else begin
						hi_s1 <= OFS_W'(WORD_BITS - 1);
						cur_q <= {cur_q[BIX_W-1:OFS_W] + 1'b1, {OFS_W{1'b0}}};
					end
				end
				ST_R_DRAIN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						was_set     <= was_q;
						set_total   <= count_q;
						range_set   <= acc_q;
						range_cells <= empty_q ? 64'd0 : prod_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
